// ===== hw/rtl/argsort_pkg.sv =====
// shared types and constants of the index sorter
package argsort_pkg;

  localparam int MAX_ITEMS = 32;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int KEY_W     = 64;
  localparam int POS_W     = 6;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic REG_DESCENDING = 1'b0;

  typedef struct packed {
    logic [KEY_W-1:0] key_value;
    logic             last_item;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             overflow;
    logic             last_result;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_value;
    logic             last_item;
    logic             descending;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

endpackage

// ===== hw/rtl/argsort_index_sorter.sv =====
// top level of the index sorter with its register port
//
// channel | direction | handshake         | payload
// in_     | request   | in_valid/in_stall | key_value, last_item
// out_    | result    | out_valid/out_stall | position, overflow, last_result
// apb     | config    | psel/penable      | descending at byte address 0
//
// requests enter a four-entry queue at one per cycle until it fills; the chain inserts one
// per cycle while filling; a last request leads to one result per stored key, one per
// cycle unless stalled, each run of equal keys set up in S_GROUP (one run when ascending)
// reset is synchronous, clears control state only; no clearing pass
// a stalled result holds the back end; the front keeps taking requests until the queue fills
module argsort_index_sorter (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  argsort_pkg::in_item_t              in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output argsort_pkg::out_item_t             out_data,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [argsort_pkg::ADDR_W-1:0]     paddr,
  input  logic [argsort_pkg::DATA_W-1:0]     pwdata,
  output logic [argsort_pkg::DATA_W-1:0]     prdata,
  output logic                               pready
);

  logic                 desc_r;
  logic                 reg_hit;
  argsort_pkg::q_head_t q_head;
  logic                 q_pop;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[argsort_pkg::ADDR_W-1] == argsort_pkg::REG_DESCENDING);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_r <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      desc_r <= pwdata[0];
    end
  end

  assign prdata = reg_hit ? {{(argsort_pkg::DATA_W-1){1'b0}}, desc_r} : '0;

  argsort_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg_desc (desc_r),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  argsort_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/argsort_front.sv =====
// front end: request intake and queue toward the sort chain
module argsort_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  argsort_pkg::in_item_t in_data,
  input  logic                  cfg_desc,
  output argsort_pkg::q_head_t  q_head,
  input  logic                  q_pop
);

  argsort_pkg::q_entry_t             mem_r [argsort_pkg::QDEPTH];
  logic [argsort_pkg::QPTR_W-1:0]    wr_r, wr_nxt;
  logic [argsort_pkg::QPTR_W-1:0]    rd_r, rd_nxt;
  logic [argsort_pkg::QPTR_W:0]      fill_r, fill_nxt;
  logic                              push;
  logic                              pop;
  argsort_pkg::q_entry_t             entry;

  assign in_stall = (fill_r == (argsort_pkg::QPTR_W + 1)'(argsort_pkg::QDEPTH));
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && (fill_r != '0);

  always_comb begin
    entry.key_value  = in_data.key_value;
    entry.last_item  = in_data.last_item;
    entry.descending = in_data.last_item ? cfg_desc : 1'b0;
  end

  always_comb begin
    wr_nxt   = push ? wr_r + 1'b1 : wr_r;
    rd_nxt   = pop ? rd_r + 1'b1 : rd_r;
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (!push && pop) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= '0;
      rd_r   <= '0;
      fill_r <= '0;
    end else begin
      wr_r   <= wr_nxt;
      rd_r   <= rd_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= entry;
    end
  end

  always_comb begin
    q_head.valid = (fill_r != '0);
    q_head.entry = mem_r[rd_r];
  end

endmodule

// ===== hw/rtl/argsort_back.sv =====
// back end: insertion sort chain, group sequencer and result register
module argsort_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  argsort_pkg::q_head_t   q_head,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output argsort_pkg::out_item_t out_data
);

  typedef enum logic [2:0] {
    S_FILL  = 3'b001,
    S_GROUP = 3'b010,
    S_EMIT  = 3'b100
  } state_t;

  state_t                            state_r, state_nxt;
  logic [argsort_pkg::KEY_W-1:0]     key_r [argsort_pkg::MAX_ITEMS];
  logic [argsort_pkg::IDX_W-1:0]     pos_r [argsort_pkg::MAX_ITEMS];
  logic [argsort_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic                              dropped_r, dropped_nxt;
  logic                              desc_r, desc_nxt;
  logic [argsort_pkg::IDX_W-1:0]     cur_r, cur_nxt;
  logic [argsort_pkg::IDX_W-1:0]     lo_r, lo_nxt;
  logic [argsort_pkg::IDX_W-1:0]     hi_r, hi_nxt;
  logic                              out_valid_r, out_valid_nxt;
  argsort_pkg::out_item_t            out_data_r;
  logic [argsort_pkg::MAX_ITEMS-1:0] shift;
  logic [argsort_pkg::MAX_ITEMS-1:0] take;
  logic [argsort_pkg::MAX_ITEMS-1:0] head;
  logic [argsort_pkg::IDX_W-1:0]     grp_lo;
  logic                              full;
  logic                              insert;
  logic                              emit_go;
  logic                              run_end;
  logic [argsort_pkg::CNT_W-1:0]     count_after;

  assign full    = (count_r == argsort_pkg::CNT_W'(argsort_pkg::MAX_ITEMS));
  assign q_pop   = (state_r == S_FILL) && q_head.valid;
  assign insert  = q_pop && !full;
  assign emit_go = (state_r == S_EMIT) && (!out_valid_r || !out_stall);
  assign run_end = (cur_r == hi_r) && (lo_r == '0);
  assign count_after = insert ? count_r + 1'b1 : count_r;

  // cells above the new key move up by one
  always_comb begin
    for (int i = 0; i < argsort_pkg::MAX_ITEMS; i++) begin
      shift[i] = (argsort_pkg::CNT_W'(i) < count_r) && (key_r[i] > q_head.entry.key_value);
      take[i]  = shift[i] || (argsort_pkg::CNT_W'(i) == count_r);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < argsort_pkg::MAX_ITEMS; i++) begin
      if (insert && take[i]) begin
        if (i > 0 && shift[(i > 0) ? i - 1 : 0]) begin
          key_r[i] <= key_r[(i > 0) ? i - 1 : 0];
          pos_r[i] <= pos_r[(i > 0) ? i - 1 : 0];
        end else begin
          key_r[i] <= q_head.entry.key_value;
          pos_r[i] <= argsort_pkg::IDX_W'(count_r);
        end
      end
    end
  end

  // start of each run of equal keys, and the highest one at or below hi
  always_comb begin
    head[0] = 1'b1;
    for (int i = 1; i < argsort_pkg::MAX_ITEMS; i++) begin
      head[i] = (key_r[i] != key_r[i-1]);
    end
    grp_lo = '0;
    for (int i = 0; i < argsort_pkg::MAX_ITEMS; i++) begin
      if (head[i] && (argsort_pkg::IDX_W'(i) <= hi_r)) begin
        grp_lo = argsort_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    dropped_nxt   = dropped_r;
    desc_nxt      = desc_r;
    cur_nxt       = cur_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;
    unique case (state_r)
      S_FILL: begin
        if (q_pop) begin
          count_nxt = count_after;
          if (full) begin
            dropped_nxt = 1'b1;
          end
          if (q_head.entry.last_item) begin
            desc_nxt  = q_head.entry.descending;
            hi_nxt    = argsort_pkg::IDX_W'(count_after - 1'b1);
            state_nxt = S_GROUP;
          end
        end
      end
      S_GROUP: begin
        lo_nxt    = desc_r ? grp_lo : '0;
        cur_nxt   = desc_r ? grp_lo : '0;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          if (cur_r == hi_r) begin
            if (lo_r == '0) begin
              count_nxt   = '0;
              dropped_nxt = 1'b0;
              state_nxt   = S_FILL;
            end else begin
              hi_nxt    = lo_r - 1'b1;
              state_nxt = S_GROUP;
            end
          end else begin
            cur_nxt = cur_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      desc_r      <= 1'b0;
      cur_r       <= '0;
      lo_r        <= '0;
      hi_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      desc_r      <= desc_nxt;
      cur_r       <= cur_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_data_r.position    <= argsort_pkg::POS_W'(pos_r[cur_r]);
      out_data_r.overflow    <= dropped_r;
      out_data_r.last_result <= run_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/argsort_chk.sv =====
// port checker for the index sorter and its bind
module argsort_chk (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_stall,
  input argsort_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.position < argsort_pkg::POS_W'(argsort_pkg::MAX_ITEMS))
    else $error("position beyond capacity");

  a_ovf_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_result ##1 out_valid
      |-> out_data.overflow == $past(out_data.overflow))
    else $error("overflow flag changed within a run");

endmodule

bind argsort_index_sorter argsort_chk u_chk (.*);

// ===== sim/testbench.sv =====
// testbench for the index sorter: directed and random key sets checked against a ranking model
`timescale 1ns / 1ps

module testbench;

  localparam int HALF_PERIOD   = 4;
  localparam int RESET_CYCLES  = 12;
  localparam int IDLE_PERCENT  = 11;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_KEYS   = 270;
  localparam int RANDOM_PHASES = 6;

  localparam logic [argsort_pkg::ADDR_W-1:0] ADDR_DESCENDING =
    argsort_pkg::ADDR_W'(4 * argsort_pkg::REG_DESCENDING);
  localparam logic [argsort_pkg::ADDR_W-1:0] ADDR_UNUSED     = argsort_pkg::ADDR_W'(4);

  typedef enum int {KEYS_WIDE, KEYS_TIED, KEYS_EDGES} key_mix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  argsort_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  argsort_pkg::out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [argsort_pkg::ADDR_W-1:0] paddr = '0;
  logic [argsort_pkg::DATA_W-1:0] pwdata = '0;
  logic [argsort_pkg::DATA_W-1:0] prdata;
  logic pready;

  argsort_index_sorter u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #HALF_PERIOD clk = ~clk;

  logic [argsort_pkg::KEY_W-1:0] run_keys[$];
  logic run_dropped = 1'b0;
  logic desc_setting = 1'b0;
  argsort_pkg::out_item_t sorted_positions[$];
  bit quiet = 1'b0;
  int hold_left = 0;
  int fail_count = 0;
  int keys_accepted = 0;
  int runs_sorted = 0;
  int overflow_runs = 0;
  int results_seen = 0;

  function automatic bit ahead_of(logic [argsort_pkg::KEY_W-1:0] a, int pa,
                                  logic [argsort_pkg::KEY_W-1:0] b, int pb, logic desc);
    if (a == b) return pa < pb;
    return desc ? (a > b) : (a < b);
  endfunction

  // rank every stored key and queue its position in sorted order
  task automatic rank_run();
    int n;
    int rank;
    int order[argsort_pkg::MAX_ITEMS];
    argsort_pkg::out_item_t res;
    n = run_keys.size();
    for (int i = 0; i < n; i++) begin
      rank = 0;
      for (int j = 0; j < n; j++)
        if (j != i && ahead_of(run_keys[j], j, run_keys[i], i, desc_setting)) rank++;
      order[rank] = i;
    end
    for (int i = 0; i < n; i++) begin
      res.position    = argsort_pkg::POS_W'(order[i]);
      res.overflow    = run_dropped;
      res.last_result = (i == n - 1);
      sorted_positions.push_back(res);
    end
    runs_sorted++;
    if (run_dropped) overflow_runs++;
    run_keys.delete();
    run_dropped = 1'b0;
  endtask

  task automatic record_key(input logic [argsort_pkg::KEY_W-1:0] key, input logic last);
    keys_accepted++;
    if (run_keys.size() < argsort_pkg::MAX_ITEMS) run_keys.push_back(key);
    else run_dropped = 1'b1;
    if (last) rank_run();
  endtask

  task automatic send_key(input logic [argsort_pkg::KEY_W-1:0] key, input logic last);
    if (!quiet) begin
      while ($urandom_range(99) < IDLE_PERCENT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data.key_value <= key;
    in_data.last_item <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    record_key(key, last);
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    release_input();
    while (sorted_positions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [argsort_pkg::ADDR_W-1:0] addr,
                           input logic [argsort_pkg::DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_DESCENDING) desc_setting = data[0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_read_check();
    logic [argsort_pkg::DATA_W-1:0] want;
    want = {{(argsort_pkg::DATA_W-1){1'b0}}, desc_setting};
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_DESCENDING;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      $error("descending readback: expected %h, actual %h", want, prdata);
      fail_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [argsort_pkg::KEY_W-1:0] pick_key(key_mix_t mix);
    case (mix)
      KEYS_TIED: return argsort_pkg::KEY_W'($urandom_range(3));
      KEYS_EDGES: begin
        case ($urandom_range(3))
          0: return '0;
          1: return '1;
          2: return {1'b1, {(argsort_pkg::KEY_W-1){1'b0}}};
          default: return {$urandom, $urandom};
        endcase
      end
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_run(input int n, input key_mix_t mix);
    for (int i = 0; i < n; i++) send_key(pick_key(mix), i == n - 1);
  endtask

  task automatic test_register_access();
    cfg_read_check();
    cfg_write(ADDR_DESCENDING, 32'hFFFF_FFFF);
    cfg_read_check();
    cfg_write(ADDR_DESCENDING, 32'hFFFF_FFFE);
    cfg_read_check();
    cfg_write(ADDR_UNUSED, 32'hFFFF_FFFF);
    cfg_read_check();
  endtask

  task automatic test_single_key();
    send_key('1, 1'b1);
    wait_idle();
  endtask

  task automatic test_extremes_and_ties();
    logic [argsort_pkg::KEY_W-1:0] keys[8];
    keys = '{'1, '0, 64'd5, '1, '0, 64'd5, {1'b1, 63'd0}, 64'd5};
    for (int d = 0; d < 2; d++) begin
      cfg_write(ADDR_DESCENDING, argsort_pkg::DATA_W'(d));
      foreach (keys[i]) send_key(keys[i], i == 7);
      wait_idle();
    end
  endtask

  task automatic test_store_full();
    send_run(argsort_pkg::MAX_ITEMS + 2, KEYS_WIDE);
    wait_idle();
    cfg_write(ADDR_DESCENDING, 32'h0);
    send_run(argsort_pkg::MAX_ITEMS, KEYS_TIED);
    wait_idle();
  endtask

  task automatic test_backpressure();
    hold_left = HOLD_CYCLES;
    for (int r = 0; r < 3; r++) send_run(8, KEYS_WIDE);
    wait_idle();
  endtask

  task automatic test_random_runs();
    int sent;
    int n;
    int pick;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      quiet = (p == 1);
      cfg_write(ADDR_DESCENDING, {$urandom} ^ argsort_pkg::DATA_W'(p % 2));
      cfg_read_check();
      sent = 0;
      while (sent < RANDOM_KEYS / RANDOM_PHASES) begin
        pick = $urandom_range(99);
        if (pick < 70) n = $urandom_range(8, 1);
        else if (pick < 85) n = $urandom_range(argsort_pkg::MAX_ITEMS, 9);
        else if (pick < 93) n = argsort_pkg::MAX_ITEMS;
        else n = $urandom_range(argsort_pkg::MAX_ITEMS + 8, argsort_pkg::MAX_ITEMS + 1);
        send_run(n, key_mix_t'($urandom_range(2)));
        sent += n;
      end
      wait_idle();
    end
    quiet = 1'b0;
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  always @(posedge clk) begin
    argsort_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (sorted_positions.size() == 0) begin
        $error("result with no request pending: position %0d", out_data.position);
        fail_count++;
      end else begin
        want = sorted_positions.pop_front();
        if (out_data.position !== want.position) begin
          $error("position: expected %0d, actual %0d", want.position, out_data.position);
          fail_count++;
        end
        if (out_data.overflow !== want.overflow) begin
          $error("overflow: expected %0b, actual %0b", want.overflow, out_data.overflow);
          fail_count++;
        end
        if (out_data.last_result !== want.last_result) begin
          $error("last_result: expected %0b, actual %0b", want.last_result,
                 out_data.last_result);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_access();
    test_single_key();
    test_extremes_and_ties();
    test_store_full();
    test_backpressure();
    test_random_runs();
    if (sorted_positions.size() != 0) begin
      $error("%0d sorted positions never arrived", sorted_positions.size());
      fail_count++;
    end
    $display("sorted %0d key sets from %0d keys, %0d of them past capacity, %0d results",
             runs_sorted, keys_accepted, overflow_runs, results_seen);
    $display("both sort orders, tied and extreme keys, idle gaps and a long result hold-off");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
